>>> rtl/embedding_bag_sum_assert.svh
// Assertion macros for the embedding bag sum block.
`ifndef EMBEDDING_BAG_SUM_ASSERT_SVH
`define EMBEDDING_BAG_SUM_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EBS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ebs_pkg.sv
// Shared types, constants and arithmetic for the embedding bag sum block.
package ebs_pkg;

  localparam int MAX_ROW_LENGTH = 64;
  localparam int NUM_ROWS       = 4096;
  localparam int ELEM_W         = $clog2(MAX_ROW_LENGTH);
  localparam int ROW_W          = $clog2(NUM_ROWS);
  localparam int TABLE_ADDR_W   = ROW_W + ELEM_W;
  localparam int TABLE_DEPTH    = NUM_ROWS * MAX_ROW_LENGTH;
  localparam int DATA_W         = 32;
  localparam int RL_W           = 7;

  localparam logic [RL_W-1:0] ROW_LENGTH_RESET = RL_W'(MAX_ROW_LENGTH);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_ACCUM = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } ebs_state_t;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    logic signed [DATA_W-1:0] r;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ELEM_W-1:0] last_elem(input logic [RL_W-1:0] rl);
    logic [ELEM_W-1:0] r;
    if (rl == '0) begin
      r = '0;
    end else if (rl > RL_W'(MAX_ROW_LENGTH)) begin
      r = ELEM_W'(MAX_ROW_LENGTH - 1);
    end else begin
      r = ELEM_W'(rl - RL_W'(1));
    end
    return r;
  endfunction

endpackage

>>> rtl/ebs_table.sv
// Embedding table memory with one write port and one registered read port.
module ebs_table
  import ebs_pkg::*;
(
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic        [TABLE_ADDR_W-1:0] wr_addr,
  input  logic signed [DATA_W-1:0]       wr_data,
  input  logic                           rd_en,
  input  logic        [TABLE_ADDR_W-1:0] rd_addr,
  output logic signed [DATA_W-1:0]       rd_data
);

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/embedding_bag_sum.sv
// Top level of the embedding bag sum block: command decode, row sweep and accumulator.
// A write transaction stores one table element at the accepting edge and leaves busy low.
// An accumulate transaction streams its row through the single table read port, one
// element per cycle, and holds busy high through the ST_READ sweep and the ST_DRAIN state.
// When end_bag is set, the saturated sums leave on strobe one per cycle, passing through
// the table read register and the output register, with last on the final element. The
// receiver cannot stall, so every strobe must be taken when it appears.
`include "embedding_bag_sum_assert.svh"

module embedding_bag_sum
  import ebs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode,
  input  logic        [ROW_W-1:0]  row_index,
  input  logic        [ELEM_W-1:0] element_index,
  input  logic signed [DATA_W-1:0] write_value,
  input  logic                     start_bag,
  input  logic                     end_bag,
  input  logic                     row_length_we,
  input  logic        [RL_W-1:0]   row_length_data,
  output logic                     strobe,
  output logic        [ELEM_W-1:0] out_element,
  output logic signed [DATA_W-1:0] sum_value,
  output logic                     last
);

  ebs_state_t state, state_next;

  logic [RL_W-1:0]   row_length;
  logic [ROW_W-1:0]  row_q;
  logic [ELEM_W-1:0] len_m1;
  logic [ELEM_W-1:0] idx;
  logic              end_q;
  logic              issue;
  logic              accept;
  logic              accept_wr;
  logic              accept_acc;

  logic signed [DATA_W-1:0] acc_mem [MAX_ROW_LENGTH];
  logic [MAX_ROW_LENGTH-1:0] acc_valid;
  logic signed [DATA_W-1:0] acc_q;
  logic signed [DATA_W-1:0] tbl_q;
  logic signed [DATA_W-1:0] sum;

  logic              s1_valid;
  logic [ELEM_W-1:0] s1_elem;
  logic              s1_last;

  assign accept     = start && !busy;
  assign accept_wr  = accept && (opcode == OP_WRITE);
  assign accept_acc = accept && (opcode == OP_ACCUM);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_acc) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (idx == len_m1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_READ: begin
        issue = 1'b1;
      end
      ST_DRAIN: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
    end else if (row_length_we) begin
      row_length <= row_length_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_acc) begin
      row_q  <= row_index;
      len_m1 <= last_elem(row_length);
      end_q  <= end_bag;
      idx    <= '0;
    end else if (issue) begin
      idx <= idx + ELEM_W'(1);
    end
  end

  ebs_table u_table (
    .clk     (clk),
    .wr_en   (accept_wr),
    .wr_addr ({row_index, element_index}),
    .wr_data (write_value),
    .rd_en   (issue),
    .rd_addr ({row_q, idx}),
    .rd_data (tbl_q)
  );

  always_ff @(posedge clk) begin
    if (issue) begin
      acc_q <= acc_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_elem <= idx;
      s1_last <= (idx == len_m1);
    end
  end

  assign sum = sat_add(acc_valid[s1_elem] ? acc_q : '0, tbl_q);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      acc_mem[s1_elem] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
    end else if (accept_acc && start_bag) begin
      acc_valid <= '0;
    end else if (s1_valid) begin
      acc_valid[s1_elem] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s1_valid && end_q;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      out_element <= s1_elem;
      sum_value   <= sum;
      last        <= s1_last;
    end
  end

  `EBS_ASSERT_NEXT(a_vector_contiguous, strobe && !last, strobe && (out_element == $past(out_element) + ELEM_W'(1)), "Emitted vector has a gap.")
  `EBS_ASSERT_SAME(a_last_matches_length, strobe && last, out_element == len_m1, "Last flag does not match the row length.")
  `EBS_ASSERT_NEXT(a_accum_starts_sweep, accept_acc, (state == ST_READ) && (idx == '0), "Accumulate transaction did not start the row sweep.")
  `EBS_ASSERT_SAME(a_pipe_while_busy, s1_valid, busy, "Pipeline active while the block reports idle.")

endmodule

>>> test/ebs_tb_pkg.sv
// Transaction types and the bag-sum scoreboard for the embedding bag sum testbench.
package ebs_tb_pkg;
  import ebs_pkg::*;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  typedef struct {
    logic                     opcode;
    logic        [ROW_W-1:0]  row;
    logic        [ELEM_W-1:0] elem;
    logic signed [DATA_W-1:0] value;
    logic                     open_bag;
    logic                     close_bag;
  } bag_cmd_t;

  typedef struct {
    logic        [ELEM_W-1:0] element;
    logic signed [DATA_W-1:0] sum;
    logic                     final_flag;
  } bag_sum_t;

  class bag_sum_scoreboard;
    logic signed [DATA_W-1:0] table_mem [int];
    logic signed [DATA_W-1:0] acc [MAX_ROW_LENGTH];
    logic        [RL_W-1:0]   row_length;
    bag_sum_t                 sums_due [$];
    int                       errors;
    int                       sums_seen;

    function new();
      row_length = ROW_LENGTH_RESET;
      foreach (acc[i]) acc[i] = '0;
      errors    = 0;
      sums_seen = 0;
    endfunction

    function int active_length();
      if (row_length == '0) return 1;
      if (row_length > RL_W'(MAX_ROW_LENGTH)) return MAX_ROW_LENGTH;
      return int'(row_length);
    endfunction

    function void set_row_length(input logic [RL_W-1:0] len);
      row_length = len;
    endfunction

    function logic signed [DATA_W-1:0] clamp_sum(input logic signed [DATA_W-1:0] a,
                                                 input logic signed [DATA_W-1:0] b);
      longint total;
      total = longint'(a) + longint'(b);
      if (total > SUM_MAX) total = SUM_MAX;
      if (total < SUM_MIN) total = SUM_MIN;
      return total[DATA_W-1:0];
    endfunction

    function void flag(input string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_command(input bag_cmd_t cmd);
      int       n;
      int       base;
      bag_sum_t r;
      base = int'(cmd.row) * MAX_ROW_LENGTH;
      if (cmd.opcode == OP_WRITE) begin
        table_mem[base + int'(cmd.elem)] = cmd.value;
        return;
      end
      if (cmd.open_bag) foreach (acc[i]) acc[i] = '0;
      n = active_length();
      for (int i = 0; i < n; i++) begin
        acc[i] = clamp_sum(acc[i], table_mem[base + i]);
      end
      if (cmd.close_bag) begin
        for (int i = 0; i < n; i++) begin
          r.element    = ELEM_W'(i);
          r.sum        = acc[i];
          r.final_flag = (i == n - 1);
          sums_due.insert(sums_due.size(), r);
        end
      end
    endfunction

    function void check_sum(input logic [ELEM_W-1:0] element,
                            input logic signed [DATA_W-1:0] sum, input logic final_flag);
      bag_sum_t want;
      sums_seen++;
      if (sums_due.size() == 0) begin
        flag($sformatf("Unexpected sum: element %0d value %0d last %0b",
                       element, sum, final_flag));
        return;
      end
      want = sums_due.pop_front();
      if (want.element !== element || want.sum !== sum || want.final_flag !== final_flag) begin
        flag($sformatf("Sum mismatch: expected element %0d value %0d last %0b, got %0d %0d %0b",
                       want.element, want.sum, want.final_flag, element, sum, final_flag));
      end
    endfunction

    function void close_out();
      if (sums_due.size() != 0) begin
        flag($sformatf("%0d predicted sum elements never arrived", sums_due.size()));
      end
    endfunction
  endclass

endpackage

>>> test/tb.sv
// Top-level testbench for the embedding bag sum block.
module tb;
  import ebs_pkg::*;
  import ebs_tb_pkg::*;

  localparam int ROW_TOP = NUM_ROWS - 1;
  localparam int RANDOM_ITEMS = 125;

  typedef enum {FILL_EXTREME, FILL_SMALL, FILL_MIXED} fill_style_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     opcode;
  logic        [ROW_W-1:0]  row_index;
  logic        [ELEM_W-1:0] element_index;
  logic signed [DATA_W-1:0] write_value;
  logic                     start_bag;
  logic                     end_bag;
  logic                     row_length_we;
  logic        [RL_W-1:0]   row_length_data;
  logic                     strobe;
  logic        [ELEM_W-1:0] out_element;
  logic signed [DATA_W-1:0] sum_value;
  logic                     last;

  bag_sum_scoreboard sb = new();

  logic [MAX_ROW_LENGTH-1:0] written [int];
  int   pool_rows [$];
  logic start_up = 1'b0;
  int   burst_left = 0;
  int   bag_left = 0;
  int   writes_sent = 0;
  int   sums_sent = 0;
  int   lengths_used = 0;

  embedding_bag_sum i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .row_index       (row_index),
    .element_index   (element_index),
    .write_value     (write_value),
    .start_bag       (start_bag),
    .end_bag         (end_bag),
    .row_length_we   (row_length_we),
    .row_length_data (row_length_data),
    .strobe          (strobe),
    .out_element     (out_element),
    .sum_value       (sum_value),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      sb.check_sum(out_element, sum_value, last);
    end
  end

  function automatic logic signed [DATA_W-1:0] small_value();
    return DATA_W'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        return 32'sh7FFF_FFFF;
      end
      1: begin
        return 32'sh8000_0000;
      end
      2, 3: begin
        return small_value();
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic int readable_row(input int n);
    logic [MAX_ROW_LENGTH-1:0] need;
    int r;
    need = (n >= MAX_ROW_LENGTH) ? '1 : (MAX_ROW_LENGTH'(1) << n) - 1;
    repeat (8) begin
      r = pool_rows[$urandom_range(0, pool_rows.size() - 1)];
      if ((written[r] & need) == need) return r;
    end
    return 0;
  endfunction

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    start_up = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic issue(input bag_cmd_t cmd);
    start         <= 1'b1;
    opcode        <= cmd.opcode;
    row_index     <= cmd.row;
    element_index <= cmd.elem;
    write_value   <= cmd.value;
    start_bag     <= cmd.open_bag;
    end_bag       <= cmd.close_bag;
    start_up = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(cmd);
    if (cmd.opcode == OP_WRITE) writes_sent++;
    else sums_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
      hold_off($urandom_range(1, 12));
    end
  endtask

  task automatic settle();
    if (start_up) begin
      start <= 1'b0;
      start_up = 1'b0;
    end
    while (sb.sums_due.size() != 0 || busy) @(posedge clk);
    repeat (MAX_ROW_LENGTH + 8) @(posedge clk);
  endtask

  task automatic set_length(input logic [RL_W-1:0] len);
    settle();
    row_length_we   <= 1'b1;
    row_length_data <= len;
    @(posedge clk);
    row_length_we <= 1'b0;
    sb.set_row_length(len);
    lengths_used++;
  endtask

  task automatic write_element(input int row, input int elem,
                               input logic signed [DATA_W-1:0] value,
                               input logic open_flag, input logic close_flag);
    bag_cmd_t cmd;
    cmd.opcode    = OP_WRITE;
    cmd.row       = ROW_W'(row);
    cmd.elem      = ELEM_W'(elem);
    cmd.value     = value;
    cmd.open_bag  = open_flag;
    cmd.close_bag = close_flag;
    if (!written.exists(row)) begin
      written[row] = '0;
      pool_rows.insert(pool_rows.size(), row);
    end
    written[row] = written[row] | (MAX_ROW_LENGTH'(1) << elem);
    issue(cmd);
  endtask

  task automatic sum_row(input int row, input logic open_flag, input logic close_flag);
    bag_cmd_t cmd;
    cmd.opcode    = OP_ACCUM;
    cmd.row       = ROW_W'(row);
    cmd.elem      = ELEM_W'($urandom);
    cmd.value     = $urandom;
    cmd.open_bag  = open_flag;
    cmd.close_bag = close_flag;
    issue(cmd);
  endtask

  task automatic fill_row(input int row, input fill_style_t style);
    logic signed [DATA_W-1:0] value;
    for (int e = 0; e < MAX_ROW_LENGTH; e++) begin
      case (style)
        FILL_EXTREME: begin
          value = (e % 2 == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        FILL_SMALL: begin
          value = small_value();
        end
        default: begin
          value = pick_value();
        end
      endcase
      write_element(row, e, value, 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int   random_items;
    int   phase_left;
    int   pick;
    int   n;
    int   row;
    logic open_flag;
    logic close_flag;
    logic [RL_W-1:0] len;

    random_items = 0;
    rst             <= 1'b1;
    start           <= 1'b0;
    opcode          <= OP_WRITE;
    row_index       <= '0;
    element_index   <= '0;
    write_value     <= '0;
    start_bag       <= 1'b0;
    end_bag         <= 1'b0;
    row_length_we   <= 1'b0;
    row_length_data <= ROW_LENGTH_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    fill_row(0, FILL_EXTREME);
    fill_row(ROW_TOP, FILL_SMALL);

    sum_row(0, 1'b1, 1'b1);
    sum_row(0, 1'b0, 1'b1);
    sum_row(ROW_TOP, 1'b1, 1'b0);
    sum_row(ROW_TOP, 1'b0, 1'b1);
    sum_row(ROW_TOP, 1'b0, 1'b1);
    write_element(ROW_TOP, MAX_ROW_LENGTH - 1, 32'sh8000_0000, 1'b1, 1'b1);
    write_element(ROW_TOP, 0, -32'sd1, 1'b0, 1'b0);
    write_element(0, 0, 32'sh0000_0000, 1'b1, 1'b0);
    sum_row(ROW_TOP, 1'b1, 1'b1);
    set_length(RL_W'(1));
    sum_row(0, 1'b1, 1'b1);
    write_element(0, MAX_ROW_LENGTH - 1, 32'sh7FFF_FFFF, 1'b0, 1'b1);
    sum_row(0, 1'b0, 1'b1);
    set_length('0);
    sum_row(ROW_TOP, 1'b0, 1'b1);
    sum_row(ROW_TOP, 1'b1, 1'b1);
    set_length(RL_W'(127));
    sum_row(0, 1'b1, 1'b1);
    set_length(RL_W'(MAX_ROW_LENGTH + 1));
    sum_row(ROW_TOP, 1'b0, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) len = RL_W'($urandom_range(1, 8));
      else if (pick < 14) len = RL_W'(MAX_ROW_LENGTH);
      else if (pick < 16) len = RL_W'($urandom_range(9, MAX_ROW_LENGTH - 1));
      else if (pick < 19) len = RL_W'($urandom_range(MAX_ROW_LENGTH + 1, 127));
      else len = '0;
      set_length(len);
      n = sb.active_length();
      phase_left = $urandom_range(15, 45);
      while (phase_left > 0 && random_items < RANDOM_ITEMS) begin
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 4) == 0) row = $urandom_range(0, ROW_TOP);
          else row = pool_rows[$urandom_range(0, pool_rows.size() - 1)];
          write_element(row, $urandom_range(0, MAX_ROW_LENGTH - 1), pick_value(),
                        1'($urandom), 1'($urandom));
        end else begin
          if (bag_left == 0) begin
            bag_left  = $urandom_range(1, 4);
            open_flag = ($urandom_range(0, 9) != 0);
          end else begin
            open_flag = ($urandom_range(0, 19) == 0);
          end
          close_flag = (bag_left == 1) || ($urandom_range(0, 19) == 0);
          bag_left--;
          sum_row(readable_row(n), open_flag, close_flag);
        end
        phase_left--;
        random_items++;
      end
    end

    settle();
    sb.close_out();
    $display("Run covered %0d table writes and %0d row sums over %0d row length settings,",
             writes_sent, sums_sent, lengths_used);
    $display("with %0d emitted sum elements checked against the predicted bag totals.",
             sb.sums_seen);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/ebs_pkg.sv
rtl/ebs_table.sv
rtl/embedding_bag_sum.sv
test/ebs_tb_pkg.sv
test/tb.sv
